// ===== rtl/tdfsm_pkg.sv =====
// ----------------------------------------------------------------------------
// tdfsm_pkg
// Shared types and constants for the table-driven state machine engine:
// item function codes, result status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tdfsm_pkg;

  localparam int TABLE_DEPTH_DEF = 32;
  localparam int RING_DEPTH_DEF  = 16;
  localparam int STATE_BITS      = 5;
  localparam int EVENT_BITS      = 6;

  typedef enum logic [1:0] {
    FUNC_ADD      = 2'd0,
    FUNC_POST     = 2'd1,
    FUNC_START    = 2'd2,
    FUNC_DISPATCH = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_TABLE_FULL  = 2'd1,
    ST_QUEUE_FULL  = 2'd2,
    ST_QUEUE_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_RESP
  } ctrl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch;  // capture the accepted item, clear the result
    logic exec;   // run add/post/start, or pop for dispatch
    logic scan;   // one step of the transition table scan
    logic load;   // move the result into the output register
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    func_t func;
    logic  empty;  // event ring holds nothing
    logic  hit;    // scan found a matching transition
    logic  miss;   // scan ran past the last used entry
  } dp_stat_t;

  typedef struct packed {
    logic [STATE_BITS-1:0] from_state;
    logic [EVENT_BITS-1:0] ev_code;
    logic [STATE_BITS-1:0] to_state;
  } tbl_entry_t;

endpackage

// ===== rtl/tdfsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdfsm_ctrl
// Sequencer: accepts one item, steps the datapath through execute and
// table scan, then hands the result to the output register.
// ----------------------------------------------------------------------------
module tdfsm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  tdfsm_pkg::dp_stat_t   stat,
  output tdfsm_pkg::ctrl_cmd_t  cmd
);

  tdfsm_pkg::ctrl_state_t state, state_next;
  logic                   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tdfsm_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      tdfsm_pkg::S_IDLE: begin
        if (in_valid) state_next = tdfsm_pkg::S_EXEC;
      end
      tdfsm_pkg::S_EXEC: begin
        if (stat.func == tdfsm_pkg::FUNC_DISPATCH && !stat.empty) begin
          state_next = tdfsm_pkg::S_SCAN;
        end else begin
          state_next = tdfsm_pkg::S_RESP;
        end
      end
      tdfsm_pkg::S_SCAN: begin
        if (stat.hit || stat.miss) state_next = tdfsm_pkg::S_RESP;
      end
      tdfsm_pkg::S_RESP: begin
        if (!out_valid || out_ready) state_next = tdfsm_pkg::S_IDLE;
      end
      default: state_next = tdfsm_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      tdfsm_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      tdfsm_pkg::S_EXEC: cmd.exec = 1'b1;
      tdfsm_pkg::S_SCAN: cmd.scan = 1'b1;
      tdfsm_pkg::S_RESP: cmd.load = !out_valid || out_ready;
      default: cmd = '0;
    endcase
    if (cmd.load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// ===== rtl/tdfsm_dpath.sv =====
// ----------------------------------------------------------------------------
// tdfsm_dpath
// Datapath: transition table memory, event ring memory with head/tail
// pointers, present state, pipelined table scan and result registers.
// ----------------------------------------------------------------------------
module tdfsm_dpath #(
  parameter int TABLE_DEPTH = tdfsm_pkg::TABLE_DEPTH_DEF,
  parameter int RING_DEPTH  = tdfsm_pkg::RING_DEPTH_DEF,
  localparam int RIDX_W     = $clog2(RING_DEPTH)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  tdfsm_pkg::ctrl_cmd_t             cmd,
  output tdfsm_pkg::dp_stat_t              stat,
  input  logic                             cfg_we,
  input  logic                             cfg_data,
  input  logic [1:0]                       func,
  input  logic [tdfsm_pkg::STATE_BITS-1:0] state_a,
  input  logic [tdfsm_pkg::EVENT_BITS-1:0] event_code,
  input  logic [tdfsm_pkg::STATE_BITS-1:0] state_b,
  output logic [1:0]                       status,
  output logic                             moved,
  output logic [tdfsm_pkg::EVENT_BITS-1:0] event_out,
  output logic [tdfsm_pkg::STATE_BITS-1:0] exit_state,
  output logic [tdfsm_pkg::STATE_BITS-1:0] entry_state,
  output logic                             requeued,
  output logic [tdfsm_pkg::STATE_BITS-1:0] current_state,
  output logic [RIDX_W-1:0]                queued_count
);

  localparam int TIDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int TCNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [TCNT_W-1:0] TABLE_FULL = TCNT_W'(TABLE_DEPTH);
  localparam logic [RIDX_W-1:0] RING_LAST  = RIDX_W'(RING_DEPTH - 1);
  localparam logic [RIDX_W:0]   RING_SPAN  = (RIDX_W + 1)'(RING_DEPTH);

  // Memories
  tdfsm_pkg::tbl_entry_t            tbl_mem [TABLE_DEPTH];
  logic [tdfsm_pkg::EVENT_BITS-1:0] ring_mem [RING_DEPTH];

  // Control state
  logic                             flush;
  logic [tdfsm_pkg::STATE_BITS-1:0] present;
  logic [TCNT_W-1:0]                used;
  logic [RIDX_W-1:0]                head;
  logic [RIDX_W-1:0]                tail;
  logic [TCNT_W-1:0]                rd_idx;
  logic                             cmp_vld;

  // Item and read data
  tdfsm_pkg::func_t                 func_q;
  logic [tdfsm_pkg::STATE_BITS-1:0] sa_q;
  logic [tdfsm_pkg::EVENT_BITS-1:0] ev_q;
  logic [tdfsm_pkg::STATE_BITS-1:0] sb_q;
  tdfsm_pkg::tbl_entry_t            tbl_q;
  logic [tdfsm_pkg::EVENT_BITS-1:0] ring_q;

  // Result being built
  tdfsm_pkg::status_t               res_status;
  logic                             res_moved;
  logic [tdfsm_pkg::EVENT_BITS-1:0] res_ev;
  logic [tdfsm_pkg::STATE_BITS-1:0] res_exit;
  logic [tdfsm_pkg::STATE_BITS-1:0] res_entry;
  logic                             res_requeued;

  logic [RIDX_W-1:0]                head_inc, tail_inc, count;
  logic                             ring_full, ring_empty, tbl_full;
  logic                             issue, match, scan_miss, is_push;
  logic                             ring_we, ring_pop, tbl_we;
  logic [tdfsm_pkg::EVENT_BITS-1:0] ring_wdata;

  always_comb begin
    head_inc   = (head == RING_LAST) ? '0 : head + 1'b1;
    tail_inc   = (tail == RING_LAST) ? '0 : tail + 1'b1;
    ring_full  = head_inc == tail;
    ring_empty = head == tail;
    tbl_full   = used == TABLE_FULL;
    issue      = rd_idx < used;
    match      = cmp_vld && tbl_q.from_state == present && tbl_q.ev_code == ring_q;
    scan_miss  = !cmp_vld && !issue;
    is_push    = func_q == tdfsm_pkg::FUNC_POST || func_q == tdfsm_pkg::FUNC_START;
    ring_we    = (cmd.exec && is_push && !ring_full) || (cmd.scan && scan_miss && !flush);
    ring_wdata = cmd.exec ? ev_q : ring_q;
    ring_pop   = cmd.exec && func_q == tdfsm_pkg::FUNC_DISPATCH && !ring_empty;
    tbl_we     = cmd.exec && func_q == tdfsm_pkg::FUNC_ADD && !tbl_full;
    if (head >= tail) begin
      count = RIDX_W'({1'b0, head} - {1'b0, tail});
    end else begin
      count = RIDX_W'({1'b0, head} + RING_SPAN - {1'b0, tail});
    end
    stat.func  = func_q;
    stat.empty = ring_empty;
    stat.hit   = match;
    stat.miss  = scan_miss;
  end

  // Table memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[used[TIDX_W-1:0]] <= '{from_state: sa_q, ev_code: ev_q, to_state: sb_q};
    end
    if (cmd.scan && issue) begin
      tbl_q <= tbl_mem[rd_idx[TIDX_W-1:0]];
    end
  end

  // Event ring memory
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[head_inc] <= ring_wdata;
    end
    if (ring_pop) begin
      ring_q <= ring_mem[tail_inc];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flush   <= 1'b0;
      present <= '0;
      used    <= '0;
      head    <= '0;
      tail    <= '0;
      cmp_vld <= 1'b0;
      rd_idx  <= '0;
    end else begin
      if (cfg_we) flush <= cfg_data;
      if (tbl_we) used <= used + 1'b1;
      if (ring_we) head <= head_inc;
      if (ring_pop) tail <= tail_inc;
      if (cmd.exec && func_q == tdfsm_pkg::FUNC_START) begin
        present <= sa_q;
      end else if (cmd.scan && match) begin
        present <= tbl_q.to_state;
      end
      if (cmd.exec) begin
        rd_idx  <= '0;
        cmp_vld <= 1'b0;
      end else if (cmd.scan) begin
        cmp_vld <= issue;
        if (issue) rd_idx <= rd_idx + 1'b1;
      end
    end
  end

  // Item capture and result build
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_q       <= tdfsm_pkg::func_t'(func);
      sa_q         <= state_a;
      ev_q         <= event_code;
      sb_q         <= state_b;
      res_status   <= tdfsm_pkg::ST_OK;
      res_moved    <= 1'b0;
      res_ev       <= '0;
      res_exit     <= '0;
      res_entry    <= '0;
      res_requeued <= 1'b0;
    end
    if (cmd.exec) begin
      case (func_q)
        tdfsm_pkg::FUNC_ADD: begin
          if (tbl_full) res_status <= tdfsm_pkg::ST_TABLE_FULL;
        end
        tdfsm_pkg::FUNC_POST, tdfsm_pkg::FUNC_START: begin
          if (ring_full) res_status <= tdfsm_pkg::ST_QUEUE_FULL;
        end
        tdfsm_pkg::FUNC_DISPATCH: begin
          if (ring_empty) res_status <= tdfsm_pkg::ST_QUEUE_EMPTY;
        end
        default: res_status <= tdfsm_pkg::ST_OK;
      endcase
    end
    if (cmd.scan) begin
      res_ev <= ring_q;
      if (match) begin
        res_moved <= 1'b1;
        res_exit  <= present;
        res_entry <= tbl_q.to_state;
      end else if (scan_miss && !flush) begin
        res_requeued <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status        <= res_status;
      moved         <= res_moved;
      event_out     <= res_ev;
      exit_state    <= res_exit;
      entry_state   <= res_entry;
      requeued      <= res_requeued;
      current_state <= present;
      queued_count  <= count;
    end
  end

endmodule

// ===== rtl/table_driven_fsm_with_event_queue_core.sv =====
// ----------------------------------------------------------------------------
// table_driven_fsm_with_event_queue_core
// Programmable state machine engine with a transition table and event ring.
// ----------------------------------------------------------------------------
// One item is processed at a time and each item yields exactly one result
// beat. Add, post and start pass through accept, execute and hand-off; the
// hand-off waits while an earlier result still holds the output register.
// A dispatch that pops an event adds a table scan after execute. The scan
// reads one table entry per cycle through the table memory's single read
// port and stops at the first match, or when it has run past the last used
// entry. The result sits in an output register, so the next item is
// accepted while an earlier result still waits for out_ready. The table
// and ring need no clearing pass: only written entries are ever read, so
// the block takes items straight out of reset. The flush register is
// written over the cfg channel (always ready); the user must write it only
// while idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module table_driven_fsm_with_event_queue_core #(
  parameter int TABLE_DEPTH = tdfsm_pkg::TABLE_DEPTH_DEF,
  parameter int RING_DEPTH  = tdfsm_pkg::RING_DEPTH_DEF,
  localparam int RIDX_W     = $clog2(RING_DEPTH)
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_data,
  // item channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       func,
  input  logic [tdfsm_pkg::STATE_BITS-1:0] state_a,
  input  logic [tdfsm_pkg::EVENT_BITS-1:0] event_code,
  input  logic [tdfsm_pkg::STATE_BITS-1:0] state_b,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       status,
  output logic                             moved,
  output logic [tdfsm_pkg::EVENT_BITS-1:0] event_out,
  output logic [tdfsm_pkg::STATE_BITS-1:0] exit_state,
  output logic [tdfsm_pkg::STATE_BITS-1:0] entry_state,
  output logic                             requeued,
  output logic [tdfsm_pkg::STATE_BITS-1:0] current_state,
  output logic [RIDX_W-1:0]                queued_count
);

  tdfsm_pkg::ctrl_cmd_t cmd;
  tdfsm_pkg::dp_stat_t  stat;
  logic                 cfg_we;

  // The flush register takes the write directly; never stall the cfg channel.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  // Sequencer: idle -> execute -> (scan) -> hand off result
  tdfsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Table, ring, present state, scan pipeline and output register
  tdfsm_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .RING_DEPTH  (RING_DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .func          (func),
    .state_a       (state_a),
    .event_code    (event_code),
    .state_b       (state_b),
    .status        (status),
    .moved         (moved),
    .event_out     (event_out),
    .exit_state    (exit_state),
    .entry_state   (entry_state),
    .requeued      (requeued),
    .current_state (current_state),
    .queued_count  (queued_count)
  );

`ifndef SYNTHESIS
  // Hold off new items until the current one has been handed off.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in flight");

  // Execute always follows the capture of an item.
  a_exec_after_latch: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> $past(cmd.latch))
    else $error("execute without a captured item");

  // Never overwrite a result beat that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!out_valid || out_ready))
    else $error("output register overwritten before it was taken");

  // A loaded result is presented on the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> out_valid)
    else $error("loaded result not presented");
`endif

endmodule

// ===== tb/table_driven_fsm_with_event_queue_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// table_driven_fsm_with_event_queue_core_tb
// Self-checking bench for the programmable state machine engine. A queue of
// add / post / start / dispatch items feeds a valid-ready driver, and a
// monitor mirrors the transition table, the event ring and the present state
// to predict every result beat and compare it field by field. The run steps
// through phases of sender idling and receiver stalls, and switches the
// unmatched-event flush setting between phases while the engine is quiet.
// ----------------------------------------------------------------------------
module table_driven_fsm_with_event_queue_core_tb;
  import tdfsm_pkg::*;

  localparam int PHASES         = 8;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int DRAIN_CYCLES   = 48;    // longest dispatch plus margin
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any beat
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    func_t                 func;
    logic [STATE_BITS-1:0] state_a;
    logic [EVENT_BITS-1:0] event_code;
    logic [STATE_BITS-1:0] state_b;
  } fsm_item_t;

  typedef struct packed {
    status_t               status;
    logic                  moved;
    logic [EVENT_BITS-1:0] event_out;
    logic [STATE_BITS-1:0] exit_state;
    logic [STATE_BITS-1:0] entry_state;
    logic                  requeued;
    logic [STATE_BITS-1:0] current_state;
    logic [3:0]            queued_count;
  } fsm_result_t;

  // DUT ports
  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic                  cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            func;
  logic [STATE_BITS-1:0] state_a;
  logic [EVENT_BITS-1:0] event_code;
  logic [STATE_BITS-1:0] state_b;
  logic                  out_valid;
  logic                  out_ready;
  logic [1:0]            status;
  logic                  moved;
  logic [EVENT_BITS-1:0] event_out;
  logic [STATE_BITS-1:0] exit_state;
  logic [STATE_BITS-1:0] entry_state;
  logic                  requeued;
  logic [STATE_BITS-1:0] current_state;
  logic [3:0]            queued_count;

  // Stimulus and scoreboard
  fsm_item_t   pending_items[$];
  fsm_result_t expected_results[$];
  int          items_issued;
  int          items_accepted;
  int          cfg_writes_seen;
  int          error_count;
  int          quiet_cycles;
  int          send_idle_pct;
  int          recv_stall_pct;
  logic        item_taken;

  // Edges handed to the table so far; the generator steers posts and starts
  // toward them so that dispatches actually walk the machine.
  logic [STATE_BITS-1:0] edge_src[$];
  logic [EVENT_BITS-1:0] edge_evt[$];
  logic [STATE_BITS-1:0] edge_dst[$];

  // Predictor state: transition table, event ring, present state, flush bit
  logic [STATE_BITS-1:0] rule_src[TABLE_DEPTH_DEF];
  logic [EVENT_BITS-1:0] rule_evt[TABLE_DEPTH_DEF];
  logic [STATE_BITS-1:0] rule_dst[TABLE_DEPTH_DEF];
  int                    rule_count;
  logic [EVENT_BITS-1:0] evq_mem[RING_DEPTH_DEF];
  logic [3:0]            evq_wr;
  logic [3:0]            evq_rd;
  logic [STATE_BITS-1:0] fsm_state;
  logic                  drop_unmatched;

  table_driven_fsm_with_event_queue_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .state_a       (state_a),
    .event_code    (event_code),
    .state_b       (state_b),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .moved         (moved),
    .event_out     (event_out),
    .exit_state    (exit_state),
    .entry_state   (entry_state),
    .requeued      (requeued),
    .current_state (current_state),
    .queued_count  (queued_count)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Push one event into the mirrored ring; one slot always stays empty.
  function automatic bit push_event(logic [EVENT_BITS-1:0] ev);
    logic [3:0] nxt;
    nxt = evq_wr + 4'd1;
    if (nxt == evq_rd) begin
      return 1'b0;
    end
    evq_mem[nxt] = ev;
    evq_wr = nxt;
    return 1'b1;
  endfunction

  // Advance the mirrored engine by one item and return the beat it yields.
  function automatic fsm_result_t predict_fsm_step(fsm_item_t it);
    fsm_result_t r;
    r = '0;
    r.status = ST_OK;
    case (it.func)
      FUNC_ADD: begin
        if (rule_count >= TABLE_DEPTH_DEF) begin
          r.status = ST_TABLE_FULL;
        end else begin
          rule_src[rule_count] = it.state_a;
          rule_evt[rule_count] = it.event_code;
          rule_dst[rule_count] = it.state_b;
          rule_count++;
        end
      end
      FUNC_POST: begin
        if (!push_event(it.event_code)) r.status = ST_QUEUE_FULL;
      end
      FUNC_START: begin
        // the state loads even when the start event is dropped
        fsm_state = it.state_a;
        if (!push_event(it.event_code)) r.status = ST_QUEUE_FULL;
      end
      default: begin
        if (evq_wr == evq_rd) begin
          r.status = ST_QUEUE_EMPTY;
        end else begin
          evq_rd = evq_rd + 4'd1;
          r.event_out = evq_mem[evq_rd];
          // first matching rule wins
          for (int i = 0; i < rule_count; i++) begin
            if (!r.moved && rule_src[i] == fsm_state && rule_evt[i] == r.event_out) begin
              r.moved       = 1'b1;
              r.exit_state  = fsm_state;
              r.entry_state = rule_dst[i];
              fsm_state     = rule_dst[i];
            end
          end
          // the pop just freed a slot, so a requeue cannot fail
          if (!r.moved && !drop_unmatched) r.requeued = push_event(r.event_out);
        end
      end
    endcase
    r.current_state = fsm_state;
    r.queued_count  = evq_wr - evq_rd;
    return r;
  endfunction

  function automatic string format_result(fsm_result_t r);
    return $sformatf("st=%0d mv=%0d ev=%0d exit=%0d entry=%0d rq=%0d cur=%0d cnt=%0d",
                     r.status, r.moved, r.event_out, r.exit_state, r.entry_state,
                     r.requeued, r.current_state, r.queued_count);
  endfunction

  task automatic push_item(func_t f, logic [STATE_BITS-1:0] a,
                           logic [EVENT_BITS-1:0] e, logic [STATE_BITS-1:0] b);
    fsm_item_t it;
    it.func       = f;
    it.state_a    = a;
    it.event_code = e;
    it.state_b    = b;
    pending_items.push_back(it);
    items_issued++;
    // remember only edges that will land in the table
    if (f == FUNC_ADD && edge_src.size() < TABLE_DEPTH_DEF) begin
      edge_src.push_back(a);
      edge_evt.push_back(e);
      edge_dst.push_back(b);
    end
  endtask

  // Block until every issued item is in and every predicted beat is out,
  // then let the engine settle. Sample at the falling edge to stay clear of
  // the monitor's updates.
  task automatic wait_for_drain();
    while (items_accepted != items_issued || expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Driver: hold the payload until the beat is taken, then advance to the
  // next pending item unless this cycle is chosen as a sender gap.
  always @(negedge clk) begin
    fsm_item_t next_item;
    if (rst === 1'b0) begin
      if (!in_valid || item_taken) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item  = pending_items.pop_front();
          func       <= next_item.func;
          state_a    <= next_item.state_a;
          event_code <= next_item.event_code;
          state_b    <= next_item.state_b;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: mirror config writes, predict on every accepted item and check
  // every accepted result beat against the oldest prediction.
  always @(posedge clk) begin
    fsm_result_t got;
    fsm_result_t want;
    if (rst) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= in_valid && in_ready;
      if (cfg_valid && cfg_ready) begin
        drop_unmatched = cfg_data;
        cfg_writes_seen++;
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_fsm_step('{func_t'(func), state_a, event_code,
                                                      state_b}));
        items_accepted++;
      end
      if (out_valid && out_ready) begin
        got.status        = status_t'(status);
        got.moved         = moved;
        got.event_out     = event_out;
        got.exit_state    = exit_state;
        got.entry_state   = entry_state;
        got.requeued      = requeued;
        got.current_state = current_state;
        got.queued_count  = queued_count;
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("[%0t] unexpected result beat: %s", $realtime, format_result(got));
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
              $display("[%0t] result mismatch\n  expected %s\n  actual   %s", $realtime,
                       format_result(want), format_result(got));
          end
        end
      end
    end
  end

  // Watchdog: drop the run when nothing moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog expired", $realtime);
      $display("table_driven_fsm_with_event_queue_core_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int                    phase;
    int                    n;
    int                    pick;
    int                    k;
    int                    target;
    logic [STATE_BITS-1:0] a;
    logic [STATE_BITS-1:0] b;
    logic [EVENT_BITS-1:0] e;

    // Drive every input to a known level before the first edge.
    rst            = 1'b1;
    cfg_valid      = 1'b0;
    cfg_data       = 1'b0;
    in_valid       = 1'b0;
    func           = FUNC_ADD;
    state_a        = '0;
    event_code     = '0;
    state_b        = '0;
    out_ready      = 1'b0;
    items_issued   = 0;
    items_accepted = 0;
    cfg_writes_seen = 0;
    error_count    = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rule_count     = 0;
    evq_wr         = '0;
    evq_rd         = '0;
    fsm_state      = '0;
    drop_unmatched = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (phase = 0; phase < PHASES; phase++) begin
      // Idling mode: none, sender gaps, receiver stalls, both.
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase

      // Write the flush bit while the engine is quiet; each idling mode sees
      // both settings across the run.
      @(negedge clk);
      target = cfg_writes_seen + 1;
      cfg_valid <= 1'b1;
      cfg_data  <= 1'((phase ^ (phase >> 2)) & 1);
      while (cfg_writes_seen != target) @(negedge clk);
      cfg_valid <= 1'b0;

      if (phase == 0) begin
        // Directed opener, flush off.
        push_item(FUNC_DISPATCH, 5'd0, 6'd0, 5'd0);     // dispatch on an empty ring
        push_item(FUNC_ADD, 5'd31, 6'd63, 5'd0);        // field maxima
        push_item(FUNC_ADD, 5'd0, 6'd0, 5'd31);         // field minima, event code 0
        push_item(FUNC_START, 5'd31, 6'd63, 5'd0);
        push_item(FUNC_DISPATCH, 5'd0, 6'd0, 5'd0);     // move 31 -> 0
        push_item(FUNC_POST, 5'd0, 6'd0, 5'd0);         // code 0 queues like any code
        push_item(FUNC_DISPATCH, 5'd31, 6'd63, 5'd31);  // move 0 -> 31, fields ignored
        push_item(FUNC_POST, 5'd0, 6'd5, 5'd0);
        push_item(FUNC_DISPATCH, 5'd0, 6'd0, 5'd0);     // no rule: requeue
        // Fill the ring to its limit, then overflow it with a post and a start.
        for (n = 0; n < RING_DEPTH_DEF - 1; n++) begin
          push_item(FUNC_POST, 5'd0, 6'(n + 10), 5'd0);
        end
        push_item(FUNC_START, 5'd7, 6'd1, 5'd0);        // dropped, state still loads
      end

      // Random part: mostly steered toward known edges, the rest noise.
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        a = STATE_BITS'($urandom_range(31));
        e = EVENT_BITS'($urandom_range(63));
        b = STATE_BITS'($urandom_range(31));
        k = (edge_src.size() != 0) ? $urandom_range(edge_src.size() - 1) : 0;
        if (pick < 6) begin
          // chain new edges off existing targets half the time
          if (edge_src.size() != 0 && $urandom_range(1)) a = edge_dst[k];
          push_item(FUNC_ADD, a, e, b);
        end else if (pick < 40) begin
          if (edge_src.size() != 0 && $urandom_range(9) < 7) e = edge_evt[k];
          push_item(FUNC_POST, a, e, b);
        end else if (pick < 48) begin
          if (edge_src.size() != 0 && $urandom_range(9) < 6) begin
            a = edge_src[k];
            e = edge_evt[k];
          end
          push_item(FUNC_START, a, e, b);
        end else begin
          push_item(FUNC_DISPATCH, a, e, b);
        end
      end

      wait_for_drain();
    end

    if (expected_results.size() != 0) begin
      $display("[%0t] %0d expected result beats never arrived", $realtime,
               expected_results.size());
      error_count += expected_results.size();
    end
    if (error_count == 0) begin
      $display("table_driven_fsm_with_event_queue_core_tb: PASS");
    end else begin
      $display("table_driven_fsm_with_event_queue_core_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tdfsm_pkg.sv
rtl/tdfsm_ctrl.sv
rtl/tdfsm_dpath.sv
rtl/table_driven_fsm_with_event_queue_core.sv
tb/table_driven_fsm_with_event_queue_core_tb.sv
